@@ rtl/pvtc_pkg.sv @@
// shared types, constants and the arctangent table of the vertex turn cost block
package pvtc_pkg;

  localparam int unsigned COORD_W     = 16;
  localparam int unsigned POINT_W     = 3 * COORD_W;
  localparam int unsigned DIFF_W      = COORD_W + 1;
  localparam int unsigned PROD_W      = 2 * DIFF_W;
  localparam int unsigned CROSS_W     = PROD_W + 1;
  localparam int unsigned DOT_W       = PROD_W + 2;
  localparam int unsigned LEN_W       = 34;
  localparam int unsigned MAG_W       = 31;
  localparam int unsigned AD_W        = 35;
  localparam int unsigned SQ_W        = 2 * MAG_W;
  localparam int unsigned SQSUM_W     = 64;
  localparam int unsigned ROOT_W      = 32;
  localparam int unsigned CORD_W      = 40;
  localparam int unsigned ANG_W       = 16;
  localparam int unsigned Z_W         = 18;
  localparam int unsigned COST_W      = 50;
  localparam int unsigned MAX_ITERS   = 24;
  localparam int unsigned ANGLE_ITERATIONS_DEF = 16;
  localparam int signed   ANGLE_PI      = 25736;
  localparam int signed   ANGLE_HALF_PI = 12868;

  // window control handed to the point cells
  typedef struct packed {
    logic shift;
    logic clr;
  } pvtc_win_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_SUM,
    ST_NORM,
    ST_SQ,
    ST_SSUM,
    ST_SQGO,
    ST_SQRT,
    ST_CDGO,
    ST_CORD,
    ST_ANGLE,
    ST_COST,
    ST_DONE
  } pvtc_state_t;

  // round(atan(2^-i) * 8192)
  function automatic logic [12:0] atan_q13(input logic [4:0] idx);
    logic [12:0] v;
    case (idx)
      5'd0:    v = 13'd6434;
      5'd1:    v = 13'd3798;
      5'd2:    v = 13'd2007;
      5'd3:    v = 13'd1019;
      5'd4:    v = 13'd511;
      5'd5:    v = 13'd256;
      5'd6:    v = 13'd128;
      5'd7:    v = 13'd64;
      5'd8:    v = 13'd32;
      5'd9:    v = 13'd16;
      5'd10:   v = 13'd8;
      5'd11:   v = 13'd4;
      5'd12:   v = 13'd2;
      5'd13:   v = 13'd1;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/pvtc_point_cell.sv @@
// one cell of the point window chain: holds a point, takes its neighbour's on shift
module pvtc_point_cell
  import pvtc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  pvtc_win_ctl_t      ctl,
  input  logic [POINT_W-1:0] d_in,
  output logic [POINT_W-1:0] q
);

  logic [POINT_W-1:0] pt_r;
  logic [POINT_W-1:0] pt_nxt;

  // clear wins over shift
  always_comb begin
    pt_nxt = pt_r;
    if (ctl.clr) begin
      pt_nxt = '0;
    end else if (ctl.shift) begin
      pt_nxt = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r <= '0;
    end else begin
      pt_r <= pt_nxt;
    end
  end

  assign q = pt_r;

endmodule

@@ rtl/pvtc_isqrt.sv @@
// floor square root, one result bit per cycle
module pvtc_isqrt
  import pvtc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SQSUM_W-1:0] radicand,
  output logic               done,
  output logic [ROOT_W-1:0]  root
);

  localparam int unsigned REM_W = ROOT_W + 3;
  localparam int unsigned CNT_W = $clog2(ROOT_W);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SQSUM_W-1:0] val_r, val_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [ROOT_W-1:0]  root_r, root_nxt;
  logic [REM_W-1:0]   rem_sh;
  logic [REM_W-1:0]   trial;

  // bring down two radicand bits, try the next root bit
  always_comb begin
    rem_sh   = {rem_r[REM_W-3:0], val_r[SQSUM_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      val_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      val_nxt = {val_r[SQSUM_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ROOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

@@ rtl/pvtc_cordic.sv @@
// vectoring cordic, one micro-rotation per cycle
module pvtc_cordic
  import pvtc_pkg::*;
#(
  parameter int unsigned ITERS = ANGLE_ITERATIONS_DEF
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   dot_neg,
  input  logic [ROOT_W-1:0]      mag,
  input  logic [AD_W-1:0]        dot_mag,
  output logic                   done,
  output logic signed [Z_W-1:0]  z
);

  localparam int unsigned ITERS_EFF = (ITERS > MAX_ITERS) ? MAX_ITERS : ITERS;
  localparam int unsigned CNT_W     = (ITERS_EFF > 1) ? $clog2(ITERS_EFF) : 1;

  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [CORD_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [Z_W-1:0]    z_r, z_nxt;
  logic signed [CORD_W-1:0] dx, dy;
  logic signed [Z_W-1:0]    t;

  // start vector, then rotate towards the x axis
  always_comb begin
    dx       = y_r >>> cnt_r;
    dy       = x_r >>> cnt_r;
    t        = signed'(Z_W'(atan_q13(5'(cnt_r))));
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      if (dot_neg) begin
        x_nxt = signed'(CORD_W'(mag));
        y_nxt = signed'(CORD_W'(dot_mag));
        z_nxt = Z_W'(ANGLE_HALF_PI);
      end else begin
        x_nxt = signed'(CORD_W'(dot_mag));
        y_nxt = signed'(CORD_W'(mag));
        z_nxt = '0;
      end
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + t;
      end else begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - t;
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ITERS_EFF - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign done = done_r;
  assign z    = z_r;

endmodule

@@ rtl/polyline_vertex_turn_cost.sv @@
// top level: point window chain, turning angle sequencer and cost output register
// an accepted point with a full window steps through product, sum, scaling, square, square sum,
// the bit-serial square root, the cordic loop, angle and cost states before its result is written
// and the input freed; a point without a full window goes straight to the done state, one point at a time
// the result register parts the sides: a waiting result stalls only the next write
// synchronous active-low reset clears the window, the count and the pending values
module polyline_vertex_turn_cost
  import pvtc_pkg::*;
#(
  parameter int unsigned ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [COORD_W-1:0] in_x_coord,
  input  logic signed [COORD_W-1:0] in_y_coord,
  input  logic signed [COORD_W-1:0] in_z_coord,
  input  logic                     in_end_of_contour,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [COST_W-1:0]        out_vertex_cost,
  output logic signed [ANG_W-1:0]  out_turn_angle,
  output logic [LEN_W-1:0]         out_edge_length_sq,
  output logic                     out_zero_edge
);

  pvtc_state_t state_r, state_nxt;
  pvtc_win_ctl_t win_ctl;

  logic [POINT_W-1:0] pt_in;
  logic [POINT_W-1:0] pt0, pt1, pt2;

  logic [1:0]              seen_r, seen_nxt;
  logic                    eoc_r, eoc_nxt;
  logic signed [ANG_W-1:0] pend_ang_r, pend_ang_nxt;
  logic [LEN_W-1:0]        pend_len_r, pend_len_nxt;

  logic                    ov_r, ov_nxt;
  logic [COST_W-1:0]       o_cost_r, o_cost_nxt;
  logic signed [ANG_W-1:0] o_ang_r, o_ang_nxt;
  logic [LEN_W-1:0]        o_len_r, o_len_nxt;
  logic                    o_zero_r, o_zero_nxt;

  logic sqrt_start, sqrt_done, cord_start, cord_done;
  logic [ROOT_W-1:0]     root;
  logic signed [Z_W-1:0] cord_z;

  // point window chain, oldest in cell 0
  assign pt_in = {in_z_coord, in_y_coord, in_x_coord};

  pvtc_point_cell u_cell0 (.clk(clk), .rst_n(rst_n), .ctl(win_ctl), .d_in(pt1), .q(pt0));
  pvtc_point_cell u_cell1 (.clk(clk), .rst_n(rst_n), .ctl(win_ctl), .d_in(pt2), .q(pt1));
  pvtc_point_cell u_cell2 (.clk(clk), .rst_n(rst_n), .ctl(win_ctl), .d_in(pt_in), .q(pt2));

  // edge vectors v = next - cur, w = cur - prev
  logic signed [DIFF_W-1:0] vx, vy, vz, wx, wy, wz;

  function automatic logic signed [DIFF_W-1:0] sub_c(input logic [COORD_W-1:0] a,
                                                     input logic [COORD_W-1:0] b);
    logic signed [DIFF_W-1:0] ea, eb;
    ea = signed'({a[COORD_W-1], a});
    eb = signed'({b[COORD_W-1], b});
    return ea - eb;
  endfunction

  always_comb begin
    vx = sub_c(pt2[COORD_W-1:0],             pt1[COORD_W-1:0]);
    vy = sub_c(pt2[2*COORD_W-1:COORD_W],     pt1[2*COORD_W-1:COORD_W]);
    vz = sub_c(pt2[3*COORD_W-1:2*COORD_W],   pt1[3*COORD_W-1:2*COORD_W]);
    wx = sub_c(pt1[COORD_W-1:0],             pt0[COORD_W-1:0]);
    wy = sub_c(pt1[2*COORD_W-1:COORD_W],     pt0[2*COORD_W-1:COORD_W]);
    wz = sub_c(pt1[3*COORD_W-1:2*COORD_W],   pt0[3*COORD_W-1:2*COORD_W]);
  end

  // product stage
  logic signed [PROD_W-1:0] p_vywz_r, p_vzwy_r, p_vzwx_r, p_vxwz_r, p_vxwy_r, p_vywx_r;
  logic signed [PROD_W-1:0] p_vxwx_r, p_vywy_r, p_vzwz_r, p_vxvx_r, p_vyvy_r, p_vzvz_r;
  logic                     degen_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_PROD) begin
      p_vywz_r <= vy * wz;
      p_vzwy_r <= vz * wy;
      p_vzwx_r <= vz * wx;
      p_vxwz_r <= vx * wz;
      p_vxwy_r <= vx * wy;
      p_vywx_r <= vy * wx;
      p_vxwx_r <= vx * wx;
      p_vywy_r <= vy * wy;
      p_vzwz_r <= vz * wz;
      p_vxvx_r <= vx * vx;
      p_vyvy_r <= vy * vy;
      p_vzvz_r <= vz * vz;
      degen_r  <= (vx == 0 && vy == 0 && vz == 0) || (wx == 0 && wy == 0 && wz == 0);
    end
  end

  // cross, dot and edge length sums
  logic signed [CROSS_W-1:0] cx_r, cy_r, cz_r;
  logic signed [DOT_W-1:0]   dot_r;
  logic [LEN_W-1:0]          len_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_SUM) begin
      cx_r  <= CROSS_W'(p_vywz_r) - CROSS_W'(p_vzwy_r);
      cy_r  <= CROSS_W'(p_vzwx_r) - CROSS_W'(p_vxwz_r);
      cz_r  <= CROSS_W'(p_vxwy_r) - CROSS_W'(p_vywx_r);
      dot_r <= DOT_W'(p_vxwx_r) + DOT_W'(p_vywy_r) + DOT_W'(p_vzwz_r);
      len_r <= LEN_W'(p_vxvx_r) + LEN_W'(p_vyvy_r) + LEN_W'(p_vzvz_r);
    end
  end

  // magnitudes and common scaling below 2^31
  logic [CROSS_W-1:0] acx, acy, acz, amax;
  logic [DOT_W-1:0]   adot;
  logic [1:0]         shk;
  logic [MAG_W-1:0]   ax_r, ay_r, az_r;
  logic [AD_W-1:0]    ad_r;
  logic               dneg_r, czpos_r;

  always_comb begin
    acx  = cx_r[CROSS_W-1] ? CROSS_W'(-cx_r) : CROSS_W'(cx_r);
    acy  = cy_r[CROSS_W-1] ? CROSS_W'(-cy_r) : CROSS_W'(cy_r);
    acz  = cz_r[CROSS_W-1] ? CROSS_W'(-cz_r) : CROSS_W'(cz_r);
    adot = dot_r[DOT_W-1] ? DOT_W'(-dot_r) : DOT_W'(dot_r);
    amax = (acx > acy) ? acx : acy;
    amax = (amax > acz) ? amax : acz;
    if (amax < (CROSS_W'(1) << 31)) begin
      shk = 2'd0;
    end else if (amax < (CROSS_W'(1) << 32)) begin
      shk = 2'd1;
    end else if (amax < (CROSS_W'(1) << 33)) begin
      shk = 2'd2;
    end else begin
      shk = 2'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_NORM) begin
      ax_r    <= MAG_W'(acx >> shk);
      ay_r    <= MAG_W'(acy >> shk);
      az_r    <= MAG_W'(acz >> shk);
      ad_r    <= AD_W'(adot >> shk);
      dneg_r  <= dot_r[DOT_W-1];
      czpos_r <= (cz_r > 0);
    end
  end

  // squares, then their sum
  logic [SQ_W-1:0]    sqx_r, sqy_r, sqz_r;
  logic [SQSUM_W-1:0] sqsum_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_SQ) begin
      sqx_r <= ax_r * ax_r;
      sqy_r <= ay_r * ay_r;
      sqz_r <= az_r * az_r;
    end
    if (state_r == ST_SSUM) begin
      sqsum_r <= SQSUM_W'(sqx_r) + SQSUM_W'(sqy_r) + SQSUM_W'(sqz_r);
    end
  end

  pvtc_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start), .radicand(sqsum_r),
    .done(sqrt_done), .root(root)
  );

  pvtc_cordic #(.ITERS(ANGLE_ITERATIONS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cord_start), .dot_neg(dneg_r), .mag(root),
    .dot_mag(ad_r), .done(cord_done), .z(cord_z)
  );

  // clamp and sign the angle
  logic signed [ANG_W-1:0] ang_r;
  logic signed [ANG_W-1:0] zc;

  always_comb begin
    if (cord_z < 0) begin
      zc = '0;
    end else if (cord_z > Z_W'(ANGLE_PI)) begin
      zc = ANG_W'(ANGLE_PI);
    end else begin
      zc = ANG_W'(cord_z);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_ANGLE) begin
      if (degen_r) begin
        ang_r <= '0;
      end else begin
        ang_r <= czpos_r ? -zc : zc;
      end
    end
  end

  // cost product, never above the 50-bit range for these widths
  logic signed [ANG_W:0] asum;
  logic [ANG_W-1:0]      amag;
  logic [COST_W-1:0]     cost_r;

  always_comb begin
    asum = (ANG_W+1)'(pend_ang_r) + (ANG_W+1)'(ang_r);
    amag = asum[ANG_W] ? ANG_W'(-asum) : ANG_W'(asum);
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_COST) begin
      cost_r <= COST_W'(amag) * COST_W'(pend_len_r);
    end
  end

  // sequencer and result register
  always_comb begin
    state_nxt    = state_r;
    win_ctl      = '0;
    sqrt_start   = 1'b0;
    cord_start   = 1'b0;
    seen_nxt     = seen_r;
    eoc_nxt      = eoc_r;
    pend_ang_nxt = pend_ang_r;
    pend_len_nxt = pend_len_r;
    ov_nxt       = ov_r && !out_ready;
    o_cost_nxt   = o_cost_r;
    o_ang_nxt    = o_ang_r;
    o_len_nxt    = o_len_r;
    o_zero_nxt   = o_zero_r;
    in_ready     = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          win_ctl.shift = 1'b1;
          eoc_nxt       = in_end_of_contour;
          state_nxt     = (seen_r >= 2'd2) ? ST_PROD : ST_DONE;
        end
      end
      ST_PROD:  state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_NORM;
      ST_NORM:  state_nxt = ST_SQ;
      ST_SQ:    state_nxt = ST_SSUM;
      ST_SSUM:  state_nxt = ST_SQGO;
      ST_SQGO: begin
        sqrt_start = 1'b1;
        state_nxt  = ST_SQRT;
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          state_nxt = ST_CDGO;
        end
      end
      ST_CDGO: begin
        cord_start = 1'b1;
        state_nxt  = ST_CORD;
      end
      ST_CORD: begin
        if (cord_done) begin
          state_nxt = ST_ANGLE;
        end
      end
      ST_ANGLE: state_nxt = ST_COST;
      ST_COST:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (!(seen_r == 2'd3 && ov_r && !out_ready)) begin
          if (seen_r == 2'd3) begin
            ov_nxt     = 1'b1;
            o_cost_nxt = cost_r;
            o_ang_nxt  = pend_ang_r;
            o_len_nxt  = pend_len_r;
            o_zero_nxt = (pend_len_r == '0);
          end
          if (seen_r >= 2'd2) begin
            pend_ang_nxt = ang_r;
            pend_len_nxt = len_r;
          end
          seen_nxt = (seen_r == 2'd3) ? seen_r : seen_r + 2'd1;
          if (eoc_r) begin
            win_ctl.clr  = 1'b1;
            seen_nxt     = '0;
            pend_ang_nxt = '0;
            pend_len_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      seen_r     <= '0;
      eoc_r      <= 1'b0;
      pend_ang_r <= '0;
      pend_len_r <= '0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      seen_r     <= seen_nxt;
      eoc_r      <= eoc_nxt;
      pend_ang_r <= pend_ang_nxt;
      pend_len_r <= pend_len_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_cost_r <= o_cost_nxt;
    o_ang_r  <= o_ang_nxt;
    o_len_r  <= o_len_nxt;
    o_zero_r <= o_zero_nxt;
  end

  assign out_valid          = ov_r;
  assign out_vertex_cost    = o_cost_r;
  assign out_turn_angle     = o_ang_r;
  assign out_edge_length_sq = o_len_r;
  assign out_zero_edge      = o_zero_r;

endmodule

@@ sim/polyline_vertex_turn_cost_tb.sv @@
// testbench for the polyline vertex turn cost block
`timescale 1ns / 100ps

module polyline_vertex_turn_cost_tb;
  import pvtc_pkg::*;

  localparam int NUM_RAND   = 1750;
  localparam int WDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_W-1:0] in_x_coord = '0;
  logic signed [COORD_W-1:0] in_y_coord = '0;
  logic signed [COORD_W-1:0] in_z_coord = '0;
  logic in_end_of_contour = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [COST_W-1:0] out_vertex_cost;
  logic signed [ANG_W-1:0] out_turn_angle;
  logic [LEN_W-1:0] out_edge_length_sq;
  logic out_zero_edge;

  typedef struct {
    logic [COST_W-1:0] cost;
    logic signed [ANG_W-1:0] angle;
    logic [LEN_W-1:0] len_sq;
    logic zero_edge;
  } vertex_cost_t;

  vertex_cost_t cost_q[$];
  int fail_cnt = 0;
  int req_cnt = 0;
  int res_cnt = 0;
  int idle_cnt = 0;
  bit rx_hold = 1'b0;

  // predictor state
  longint win_x[3], win_y[3], win_z[3];
  int pts_seen;
  int pend_angle;
  longint pend_len_sq;

  polyline_vertex_turn_cost u_top (.*);

  always #1 clk = ~clk;

  function automatic longint asr_floor(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int vertex_angle(int p, int c, int n);
    longint vx, vy, vz, wx, wy, wz, cx, cy, cz, dp, x, y, z, dx, dy;
    longint unsigned ax, ay, az, ad, m;
    int k;
    vx = win_x[n] - win_x[c]; vy = win_y[n] - win_y[c]; vz = win_z[n] - win_z[c];
    wx = win_x[c] - win_x[p]; wy = win_y[c] - win_y[p]; wz = win_z[c] - win_z[p];
    if ((vx == 0 && vy == 0 && vz == 0) || (wx == 0 && wy == 0 && wz == 0)) return 0;
    cx = vy * wz - vz * wy;
    cy = vz * wx - vx * wz;
    cz = vx * wy - vy * wx;
    dp = vx * wx + vy * wy + vz * wz;
    ax = cx < 0 ? -cx : cx; ay = cy < 0 ? -cy : cy;
    az = cz < 0 ? -cz : cz; ad = dp < 0 ? -dp : dp;
    m = ax > ay ? ax : ay;
    m = m > az ? m : az;
    k = 0;
    while ((m >> k) >= (64'd1 << 31)) k++;
    ax >>= k; ay >>= k; az >>= k; ad >>= k;
    x = int_sqrt(ax * ax + ay * ay + az * az);
    if (dp < 0) begin
      y = ad;
      z = ANGLE_HALF_PI;
    end else begin
      y = x;
      x = ad;
      z = 0;
    end
    for (int i = 0; i < ANGLE_ITERATIONS_DEF; i++) begin
      dx = asr_floor(y, i);
      dy = asr_floor(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += atan_q13(i[4:0]);
      end else begin
        x -= dx; y += dy; z -= atan_q13(i[4:0]);
      end
    end
    if (z < 0) z = 0;
    if (z > ANGLE_PI) z = ANGLE_PI;
    return cz > 0 ? -int'(z) : int'(z);
  endfunction

  function automatic void clear_window();
    for (int j = 0; j < 3; j++) begin
      win_x[j] = 0; win_y[j] = 0; win_z[j] = 0;
    end
    pts_seen = 0;
    pend_angle = 0;
    pend_len_sq = 0;
  endfunction

  // advance the predictor by one point
  function automatic void predict_point(logic signed [15:0] px, logic signed [15:0] py,
                                        logic signed [15:0] pz, logic last);
    int a, sum;
    longint dx, dy, dz, len;
    longint unsigned c;
    vertex_cost_t e;
    for (int j = 0; j < 2; j++) begin
      win_x[j] = win_x[j+1]; win_y[j] = win_y[j+1]; win_z[j] = win_z[j+1];
    end
    win_x[2] = px; win_y[2] = py; win_z[2] = pz;
    if (pts_seen >= 2) begin
      a = vertex_angle(0, 1, 2);
      dx = win_x[2] - win_x[1]; dy = win_y[2] - win_y[1]; dz = win_z[2] - win_z[1];
      len = dx * dx + dy * dy + dz * dz;
      if (pts_seen == 3) begin
        sum = pend_angle + a;
        c = longint'(sum < 0 ? -sum : sum) * pend_len_sq;
        if (c > (64'd1 << 50) - 1) c = (64'd1 << 50) - 1;
        e.cost = c[COST_W-1:0];
        e.angle = pend_angle[15:0];
        e.len_sq = pend_len_sq[LEN_W-1:0];
        e.zero_edge = (pend_len_sq == 0);
        cost_q.push_back(e);
      end
      pend_angle = a;
      pend_len_sq = len;
    end
    if (pts_seen < 3) pts_seen++;
    if (last) clear_window();
  endfunction

  function automatic int gap_len(int long_pct);
    int n;
    if ($urandom_range(99) < long_pct) n = $urandom_range(80, 20);
    else if ($urandom_range(2) == 0) n = 0;
    else n = $urandom_range(3, 1);
    return n;
  endfunction

  // send one point and wait for its acceptance
  task automatic send_point(logic signed [15:0] px, logic signed [15:0] py,
                            logic signed [15:0] pz, logic last, bit gaps);
    int n;
    n = 0;
    if (gaps) n = gap_len(3);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_coord <= px;
    in_y_coord <= py;
    in_z_coord <= pz;
    in_end_of_contour <= last;
    do @(posedge clk); while (!in_ready);
    predict_point(px, py, pz, last);
    req_cnt++;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (cost_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
  endtask

  // receiver: random stalls unless held off
  always @(posedge clk) begin
    if (!rst_n || rx_hold) out_ready <= 1'b0;
    else if ($urandom_range(9) < 7) out_ready <= 1'b1;
    else if ($urandom_range(9) == 0) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(1) == 1);
  end

  // result checker
  always @(posedge clk) begin
    vertex_cost_t e;
    if (rst_n && out_valid && out_ready) begin
      res_cnt++;
      if (cost_q.size() == 0) begin
        $error("unexpected result, cost %0d", out_vertex_cost);
        fail_cnt++;
      end else begin
        e = cost_q.pop_front();
        if (out_vertex_cost !== e.cost) begin
          $error("vertex_cost exp %0d got %0d", e.cost, out_vertex_cost);
          fail_cnt++;
        end
        if (out_turn_angle !== e.angle) begin
          $error("turn_angle exp %0d got %0d", e.angle, out_turn_angle);
          fail_cnt++;
        end
        if (out_edge_length_sq !== e.len_sq) begin
          $error("edge_length_sq exp %0d got %0d", e.len_sq, out_edge_length_sq);
          fail_cnt++;
        end
        if (out_zero_edge !== e.zero_edge) begin
          $error("zero_edge exp %0d got %0d", e.zero_edge, out_zero_edge);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on requests and results
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cnt);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // extremes, degenerate edges, short contours and end-of-contour restart
  task automatic test_directed();
    send_point(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0, 1);
    send_point(16'sh8000, 16'sh7fff, 16'sh8000, 1'b0, 1);
    send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, 1);
    send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, 1);
    send_point(16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 1);
    send_point(16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 1);
    send_point(16'sh0010, 16'sh0000, 16'sh0000, 1'b0, 1);
    send_point(16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 1);
    // single-point contour
    send_point(16'sh1234, -16'sh0567, 16'sh0000, 1'b1, 1);
    // two-point contour
    send_point(16'sh0001, 16'sh0002, 16'sh0003, 1'b0, 1);
    send_point(-16'sh0001, 16'sh0002, 16'sh0003, 1'b1, 1);
    // square in the plane, then a path on to a full reversal, both turning senses
    send_point(16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 1);
    send_point(16'sh0100, 16'sh0000, 16'sh0000, 1'b0, 1);
    send_point(16'sh0100, 16'sh0100, 16'sh0000, 1'b0, 1);
    send_point(16'sh0000, 16'sh0100, 16'sh0000, 1'b0, 1);
    send_point(16'sh0100, 16'sh0200, 16'sh0000, 1'b0, 1);
    send_point(16'sh0200, 16'sh0200, 16'sh0000, 1'b0, 1);
    send_point(16'sh0300, 16'sh0200, 16'sh0000, 1'b0, 1);
    send_point(16'sh0100, 16'sh0200, 16'sh0000, 1'b1, 1);
    wait_drained();
  endtask

  function automatic logic signed [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return $signed(16'($urandom_range(64))) - 16'sd32;
      default: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  // random contours of mixed length, with repeated points now and then
  task automatic test_random(int n_items);
    int sent, len, mode;
    logic signed [15:0] px, py, pz;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(40, 3);
      mode = $urandom_range(9) < 6 ? 0 : ($urandom_range(3) == 0 ? 2 : 1);
      px = rand_coord(mode); py = rand_coord(mode); pz = rand_coord(mode);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(7) != 0) begin
          px = rand_coord(mode); py = rand_coord(mode);
          pz = ($urandom_range(4) == 0) ? px : rand_coord(mode);
        end
        send_point(px, py, pz, i == len - 1, 1);
        sent++;
      end
      // pause until all costs have come back, once in a while
      if ($urandom_range(19) == 0) wait_drained();
    end
    wait_drained();
  endtask

  // long receiver hold-off while points keep coming
  task automatic test_backpressure();
    fork
      begin
        rx_hold = 1'b1;
        repeat (1500) @(posedge clk);
        rx_hold = 1'b0;
      end
      for (int i = 0; i < 30; i++)
        send_point(16'($urandom), 16'($urandom), 16'($urandom), i == 29, 0);
    join
    wait_drained();
  endtask

  initial begin
    clear_window();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(NUM_RAND);
    $display("sent %0d points, checked %0d vertex costs", req_cnt, res_cnt);
    $display("covered extremes, degenerate edges, short contours and stalls");
    if (fail_cnt == 0 && cost_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/pvtc_pkg.sv
rtl/pvtc_point_cell.sv
rtl/pvtc_isqrt.sv
rtl/pvtc_cordic.sv
rtl/polyline_vertex_turn_cost.sv
sim/polyline_vertex_turn_cost_tb.sv
